>>> hdl/npdi_pkg.sv
package npdi_pkg;

  typedef enum logic [1:0] {
    OP_TRIAL        = 2'd0,
    OP_COMMIT       = 2'd1,
    OP_REVERT_LAST  = 2'd2,
    OP_REVERT_START = 2'd3
  } op_t;

  localparam logic [2:0] MODE_FORCE     = 3'd0;
  localparam logic [2:0] MODE_DEFO      = 3'd1;
  localparam logic [2:0] MODE_PLAS_DEFO = 3'd2;
  localparam logic [2:0] MODE_ENERGY    = 3'd3;
  localparam logic [2:0] MODE_PLAS_EN   = 3'd4;

  localparam logic [1:0] CFG_POS_LIMIT = 2'd0;
  localparam logic [1:0] CFG_NEG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_MODE      = 2'd2;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic load;
    logic misc;
    logic mul;
    logic energy;
    logic div_start;
    logic div_norm;
    logic scalar;
    logic dmg_sat;
    logic dmg_take;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_trial;
    logic need_div;
    logic norm_sat;
    logic div_done;
  } sts_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'(S48_MAX)) r = S48_MAX;
    else if (v < 50'(S48_MIN)) r = S48_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage

>>> hdl/npdi_div.sv
module npdi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] rem0,
  input  logic [63:0] num,
  input  logic [32:0] den,
  input  logic [6:0]  cnt,
  output logic        done,
  output logic [63:0] quot
);
  logic [32:0] rem_r, den_r;
  logic [63:0] num_r, q_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [33:0] trial;
  logic        fits;

  // The remainder stays below the divisor, so one extra bit covers the shift.
  assign trial = {rem_r, num_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= cnt;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 7'd1;
      done_r <= (cnt_r == 7'd1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      num_r <= {num_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

>>> hdl/npdi_dp.sv
module npdi_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  npdi_pkg::cmd_t     cmd,
  output npdi_pkg::sts_t     sts,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_deformation,
  input  logic signed [31:0] in_force_req,
  input  logic signed [31:0] in_stiffness,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic [31:0]        out_damage
);
  import npdi_pkg::*;

  op_t                op_r;
  logic signed [31:0] d_r, f_r, k_r;
  logic [30:0]        pos_lim_r;
  logic signed [31:0] neg_lim_r;
  logic [2:0]         mode_r;

  logic signed [47:0] tscal_r, cscal_r, pscal_r;
  logic [31:0]        tdmg_r, cdmg_r, pdmg_r;
  logic signed [31:0] tdef_r, cdef_r, pdef_r, tfor_r, cfor_r, pfor_r;

  logic [64:0]        prod_r;
  logic               neg_r;
  logic [63:0]        sq_r;
  logic signed [47:0] energy_r, scal_r, scal_nxt;
  logic [31:0]        dmg_r, out_damage_r;

  logic signed [32:0] a, b;
  logic [32:0]        ma, mb;
  logic [31:0]        mf, mk, ndiv;
  logic [47:0]        m48, qmag, tcap, smag;
  logic signed [48:0] term, qs;
  logic signed [47:0] qsat;
  logic               div_done;
  logic [63:0]        quot;
  logic [32:0]        dv_rem0, dv_den;
  logic [63:0]        dv_num;
  logic [6:0]         dv_cnt;

  assign a  = 33'(f_r) + 33'(cfor_r);
  assign b  = 33'(d_r) - 33'(cdef_r);
  assign ma = a[32] ? 33'(33'd0 - a) : a;
  assign mb = b[32] ? 33'(33'd0 - b) : b;
  assign mf = f_r[31] ? 32'(32'd0 - f_r) : f_r;
  assign mk = k_r[31] ? 32'(32'd0 - k_r) : k_r;

  // The product never exceeds 2^64, so the shifted magnitude stays within 2^47.
  assign m48  = prod_r[64:17];
  assign term = neg_r ? 49'(49'sd0 - $signed({1'b0, m48})) : $signed({1'b0, m48});

  assign qmag = quot[47:0];
  assign qs   = (f_r[31] ^ k_r[31]) ? 49'(49'sd0 - $signed({1'b0, qmag}))
                                    : $signed({1'b0, qmag});
  assign qsat = sat48(50'(qs));
  assign tcap = (quot > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : quot[47:0];

  always_comb begin
    case (mode_r)
      MODE_FORCE:     scal_nxt = 48'(f_r);
      MODE_DEFO:      scal_nxt = 48'(d_r);
      MODE_PLAS_DEFO: scal_nxt = (k_r != '0) ? sat48(50'(d_r) - 50'(qsat)) : 48'(d_r);
      MODE_ENERGY:    scal_nxt = energy_r;
      MODE_PLAS_EN:   scal_nxt = (!k_r[31] && k_r != '0)
                                 ? sat48(50'(energy_r) - $signed({2'b0, tcap})) : '0;
      default:        scal_nxt = '0;
    endcase
  end

  assign smag = scal_r[47] ? 48'(48'd0 - scal_r) : scal_r;
  always_comb begin
    if (!scal_r[47]) ndiv = {1'b0, pos_lim_r};
    else ndiv = neg_lim_r[31] ? 32'(32'd0 - neg_lim_r) : neg_lim_r;
  end

  always_comb begin
    if (cmd.div_norm) begin
      dv_rem0 = smag[40:8];
      dv_num  = {smag[7:0], 56'd0};
      dv_den  = {1'b0, ndiv};
      dv_cnt  = 7'd32;
    end else if (mode_r == MODE_PLAS_EN) begin
      dv_rem0 = '0;
      dv_num  = sq_r;
      dv_den  = {k_r, 1'b0};
      dv_cnt  = 7'd64;
    end else begin
      dv_rem0 = '0;
      dv_num  = {mf, 32'd0};
      dv_den  = {1'b0, mk};
      dv_cnt  = 7'd48;
    end
  end

  npdi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .rem0  (dv_rem0),
    .num   (dv_num),
    .den   (dv_den),
    .cnt   (dv_cnt),
    .done  (div_done),
    .quot  (quot)
  );

  assign sts.op_trial = (op_r == OP_TRIAL);
  assign sts.need_div = (mode_r == MODE_PLAS_DEFO && k_r != '0) ||
                        (mode_r == MODE_PLAS_EN && !k_r[31] && k_r != '0);
  assign sts.norm_sat = (ndiv == '0) || (smag >= {8'd0, ndiv, 8'd0});
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lim_r <= 31'd65536;
      neg_lim_r <= -32'sd65536;
      mode_r    <= MODE_FORCE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_LIMIT: pos_lim_r <= cfg_data[30:0];
        CFG_NEG_LIMIT: neg_lim_r <= cfg_data;
        CFG_MODE:      mode_r    <= cfg_data[2:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_opcode);
      d_r  <= in_deformation;
      f_r  <= in_force_req;
      k_r  <= in_stiffness;
    end
    if (cmd.mul) begin
      prod_r <= {32'd0, ma} * {32'd0, mb};
      neg_r  <= a[32] ^ b[32];
      sq_r   <= {32'd0, mf} * {32'd0, mf};
    end
    if (cmd.energy) energy_r <= sat48(50'(cscal_r) + 50'(term));
    if (cmd.scalar) scal_r <= scal_nxt;
    if (cmd.dmg_sat) dmg_r <= 32'hFFFF_FFFF;
    else if (cmd.dmg_take) dmg_r <= quot[31:0];
    if (cmd.out_load) out_damage_r <= tdmg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.misc && op_r == OP_REVERT_START)) begin
      tscal_r <= '0; cscal_r <= '0; pscal_r <= '0;
      tdmg_r  <= '0; cdmg_r  <= '0; pdmg_r  <= '0;
      tdef_r  <= '0; cdef_r  <= '0; pdef_r  <= '0;
      tfor_r  <= '0; cfor_r  <= '0; pfor_r  <= '0;
    end else if (cmd.misc && op_r == OP_COMMIT) begin
      pscal_r <= cscal_r; pdmg_r <= cdmg_r; pdef_r <= cdef_r; pfor_r <= cfor_r;
      cscal_r <= tscal_r; cdmg_r <= tdmg_r; cdef_r <= tdef_r; cfor_r <= tfor_r;
    end else if (cmd.misc && op_r == OP_REVERT_LAST) begin
      cscal_r <= pscal_r; cdmg_r <= pdmg_r; cdef_r <= pdef_r; cfor_r <= pfor_r;
    end else if (cmd.finish) begin
      tscal_r <= scal_r;
      tdef_r  <= d_r;
      tfor_r  <= f_r;
      tdmg_r  <= (dmg_r < cdmg_r) ? cdmg_r : dmg_r;
    end
  end

  assign out_damage = out_damage_r;
endmodule

>>> hdl/npdi_ctrl.sv
module npdi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  npdi_pkg::sts_t sts,
  output npdi_pkg::cmd_t cmd
);
  import npdi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_MUL, ST_ENERGY, ST_DIV1, ST_DIV1_WAIT,
    ST_SCALAR, ST_NORM, ST_DIV2_WAIT, ST_FINISH, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op_trial) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.misc  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ENERGY;
      end
      ST_ENERGY: begin
        cmd.energy = 1'b1;
        state_nxt  = ST_DIV1;
      end
      ST_DIV1: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV1_WAIT;
        end else begin
          state_nxt = ST_SCALAR;
        end
      end
      ST_DIV1_WAIT: begin
        if (sts.div_done) state_nxt = ST_SCALAR;
      end
      ST_SCALAR: begin
        cmd.scalar = 1'b1;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        // An out-of-range quotient or a zero divisor saturates without dividing.
        if (sts.norm_sat) begin
          cmd.dmg_sat = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_norm  = 1'b1;
          state_nxt     = ST_DIV2_WAIT;
        end
      end
      ST_DIV2_WAIT: begin
        if (sts.div_done) begin
          cmd.dmg_take = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
endmodule

>>> hdl/normalized_peak_damage_index_top.sv
// Commit and revert go from decode straight to the result; a trial runs multiply,
// energy, scalar, the normalizing division and finish, and skips that division when the
// damage saturates. Plastic deformation and plastic energy add a first division on the
// shared one-bit-per-cycle divider. One request is in work at a time, so the next one is
// accepted in the cycle the result appears, later while a result waits on out_stall.
// Synchronous active-low reset clears control and record state and loads default limits.
module normalized_peak_damage_index_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_deformation,
  input  logic signed [31:0] in_force_req,
  input  logic signed [31:0] in_stiffness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_damage,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import npdi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  npdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  npdi_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_deformation (in_deformation),
    .in_force_req   (in_force_req),
    .in_stiffness   (in_stiffness),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_damage     (out_damage)
  );
endmodule

>>> hdl/npdi_chk.sv
module npdi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_damage
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_damage))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_no_result_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid || $past(in_valid))
    else $error("result appeared without a request");
endmodule

bind normalized_peak_damage_index_top npdi_chk u_chk (.*);
